// ----- rtl/core/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants for the byte double-ended queue
// ----------------------------------------------------------------------------
package bdq_pkg;

  // default ring depth
  localparam int unsigned BDQ_DEPTH = 16;

  // payload widths fixed by the interface
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CNT_OUT_W = 5;

  // operation codes, unused codes act as a peek
  typedef enum logic [OP_W-1:0] {
    OP_PEEK       = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_PUSH_FRONT = 3'd3,
    OP_POP_FRONT  = 3'd4
  } op_e;

  // status flags handed from the pointer unit to the output stage
  typedef struct packed {
    logic empty;
    logic full;
    logic dropped;
  } bdq_status_t;

endpackage

// ----- rtl/core/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bdq_ptr.sv -----
// ----------------------------------------------------------------------------
// bdq_ptr
// front pointer and entry count of the ring, write address for pushes
// ----------------------------------------------------------------------------
module bdq_ptr import bdq_pkg::*; #(
  parameter int unsigned DEPTH = BDQ_DEPTH,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [OP_W-1:0]  op_i,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [AddrW-1:0] front_addr_o,
  output logic [AddrW-1:0] back_addr_o,
  output logic [CntW-1:0]  count_o,
  output bdq_status_t      status_o
);

  localparam int unsigned SumW = CntW + 1;
  localparam logic [SumW-1:0]  DepthS   = SumW'(DEPTH);
  localparam logic [AddrW-1:0] LastIdx  = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  DepthC   = CntW'(DEPTH);

  logic [AddrW-1:0] front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             dropped_q, dropped_d;

  logic             full;
  logic             empty;
  logic [SumW-1:0]  tail_sum;
  logic [SumW-1:0]  back_sum;
  logic [AddrW-1:0] tail_idx;
  logic [AddrW-1:0] front_dec;
  logic [AddrW-1:0] front_inc;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  // slot after the back entry
  assign tail_sum = SumW'(front_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= DepthS) ? AddrW'(tail_sum - DepthS) : AddrW'(tail_sum);

  // back entry, only meaningful when not empty
  assign back_sum = tail_sum - SumW'(1);
  assign back_addr_o = (back_sum >= DepthS) ? AddrW'(back_sum - DepthS) : AddrW'(back_sum);

  assign front_dec = (front_q == '0) ? LastIdx : front_q - AddrW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AddrW'(1);

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    wr_en_o   = 1'b0;
    wr_addr_o = tail_idx;
    if (accept_i) begin
      dropped_d = 1'b0;
      unique case (op_e'(op_i))
        OP_PUSH_BACK: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            wr_en_o = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            count_d = count_q - CntW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = front_dec;
            front_d   = front_dec;
            count_d   = count_q + CntW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            front_d = front_inc;
            count_d = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign front_addr_o     = front_q;
  assign count_o          = count_q;
  assign status_o.empty   = empty;
  assign status_o.full    = full;
  assign status_o.dropped = dropped_q;

endmodule

// ----- rtl/core/byte_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// byte_double_ended_queue
// byte deque in a bounded ring, push and pop at both ends
// ----------------------------------------------------------------------------
// pacing: a new transaction is taken only after the previous one has passed the
//   update cycle, the registered read of the two ring memories and the output
//   load, which waits while the output register holds a stalled result
// reset: front pointer, count, control and output valid clear at once;
//   ring contents are not cleared and only occupied entries reach the outputs
module byte_double_ended_queue import bdq_pkg::*; #(
  parameter int unsigned DEPTH = BDQ_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [DATA_W-1:0]    push_value_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    front_value_o,
  output logic [DATA_W-1:0]    back_value_o,
  output logic [CNT_OUT_W-1:0] entry_count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o,
  output logic                 push_dropped_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  // idle takes a transaction, read waits on the ram, load fills the output
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q;

  logic             accept;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] front_addr;
  logic [AddrW-1:0] back_addr;
  logic [CntW-1:0]  count;
  bdq_status_t      status;
  logic [DATA_W-1:0] front_rdata;
  logic [DATA_W-1:0] back_rdata;
  logic [CntW+CNT_OUT_W-1:0] count_ext;
  logic             out_free;

  // output register registers
  logic                 out_valid_q;
  logic [DATA_W-1:0]    front_value_q;
  logic [DATA_W-1:0]    back_value_q;
  logic [CNT_OUT_W-1:0] entry_count_q;
  logic                 is_empty_q;
  logic                 is_full_q;
  logic                 push_dropped_q;

  // new transactions only when the previous one has left the update path;
  // the output register may still hold an untaken result meanwhile
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // pointer unit: applies the operation on the accept edge and drives
  // the write of a pushed byte in that same cycle
  bdq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (operation_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .front_addr_o(front_addr),
    .back_addr_o (back_addr),
    .count_o     (count),
    .status_o    (status)
  );

  // two mirrored copies of the ring, one read at the front, one at the back;
  // the write lands before the read cycle, so no forwarding is needed
  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram_front (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(push_value_i),
    .raddr_i(front_addr),
    .rdata_o(front_rdata)
  );

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram_back (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(push_value_i),
    .raddr_i(back_addr),
    .rdata_o(back_rdata)
  );

  // reported count is the stored count taken to the output width
  assign count_ext = {{CNT_OUT_W{1'b0}}, count};

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      front_value_q  <= '0;
      back_value_q   <= '0;
      entry_count_q  <= '0;
      is_empty_q     <= 1'b0;
      is_full_q      <= 1'b0;
      push_dropped_q <= 1'b0;
    end else begin
      // result taken downstream, unless a new one loads in its place
      if (out_valid_q && !out_stall_i && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // pointers settled, read addresses are presented this cycle
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // read data is here; hold it in the ram output until there is room
          if (out_free) begin
            out_valid_q    <= 1'b1;
            front_value_q  <= status.empty ? '0 : front_rdata;
            back_value_q   <= status.empty ? '0 : back_rdata;
            entry_count_q  <= count_ext[CNT_OUT_W-1:0];
            is_empty_q     <= status.empty;
            is_full_q      <= status.full;
            push_dropped_q <= status.dropped;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign front_value_o  = front_value_q;
  assign back_value_o   = back_value_q;
  assign entry_count_o  = entry_count_q;
  assign is_empty_o     = is_empty_q;
  assign is_full_o      = is_full_q;
  assign push_dropped_o = push_dropped_q;

endmodule

// ----- verif/byte_double_ended_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_double_ended_queue_tb
// self-checking bench for the byte deque: a local deque model predicts the
// view after every transaction, and each output transaction is compared with
// the oldest prediction; directed end cases, biased fill and drain walks,
// raw opcode noise and a final back-to-back stream with no idling
// ----------------------------------------------------------------------------
module byte_double_ended_queue_tb;
  import bdq_pkg::*;

  localparam int unsigned DEPTH = BDQ_DEPTH;

  // codes above the last operation behave as a peek
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_POP_FRONT + 1);
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

  // extra wait at the end, once no predictions are pending
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam int unsigned WALK_PHASES    = 12;
  localparam int unsigned WALK_PHASE_LEN = 100;
  localparam int unsigned NOISE_ITEMS    = 400;
  localparam int unsigned STREAM_ITEMS   = 200;

  // push shares (percent) for fill-biased and drain-biased phases
  localparam int unsigned FILL_SHARE  = 75;
  localparam int unsigned DRAIN_SHARE = 30;

  // expected view of the deque after one transaction
  typedef struct packed {
    logic [DATA_W-1:0]    front_value;
    logic [DATA_W-1:0]    back_value;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
    logic                 is_full;
    logic                 push_dropped;
  } deque_view_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      operation_i  = '0;
  logic [DATA_W-1:0]    push_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [DATA_W-1:0]    front_value_o;
  logic [DATA_W-1:0]    back_value_o;
  logic [CNT_OUT_W-1:0] entry_count_o;
  logic                 is_empty_o;
  logic                 is_full_o;
  logic                 push_dropped_o;

  // model state: ring contents, front index and occupancy
  logic [DATA_W-1:0] model_ring [DEPTH];
  int unsigned       model_front = 0;
  int unsigned       model_count = 0;

  deque_view_t pending_views [$];
  int unsigned error_count = 0;

  // random idling on both sides while set, cleared for the closing stream
  bit          idle_enable = 1'b1;
  int unsigned stall_left  = 0;

  byte_double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .push_value_i,
    .out_valid_o,
    .out_stall_i,
    .front_value_o,
    .back_value_o,
    .entry_count_o,
    .is_empty_o,
    .is_full_o,
    .push_dropped_o
  );

  always #10 clk_i = ~clk_i;

  // apply one operation to the model and return the view it leaves behind
  function automatic deque_view_t next_deque_view(input logic [OP_W-1:0] code,
                                                  input logic [DATA_W-1:0] value);
    deque_view_t view;
    logic        full;
    view = '0;
    full = (model_count >= DEPTH);
    case (code)
      OP_PUSH_BACK: begin
        if (full) begin
          view.push_dropped = 1'b1;
        end else begin
          model_ring[(model_front + model_count) % DEPTH] = value;
          model_count++;
        end
      end
      OP_POP_BACK: begin
        if (model_count != 0) model_count--;
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          view.push_dropped = 1'b1;
        end else begin
          model_front = (model_front + DEPTH - 1) % DEPTH;
          model_ring[model_front] = value;
          model_count++;
        end
      end
      OP_POP_FRONT: begin
        if (model_count != 0) begin
          model_front = (model_front + 1) % DEPTH;
          model_count--;
        end
      end
      default: ;  // peek and the spare codes leave the state alone
    endcase
    // only occupied entries are read, empty queue reports zero bytes
    if (model_count != 0) begin
      view.front_value = model_ring[model_front];
      view.back_value  = model_ring[(model_front + model_count - 1) % DEPTH];
    end
    view.entry_count = CNT_OUT_W'(model_count);
    view.is_empty    = (model_count == 0);
    view.is_full     = (model_count >= DEPTH);
    return view;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [DATA_W-1:0] expected,
                                      input logic [DATA_W-1:0] actual);
    if (actual !== expected) begin
      error_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
    end
  endfunction

  // drive one input transaction and hold it until accepted; called at a rising
  // edge and returns at one, so back-to-back calls keep valid high without a
  // second assignment in the same step
  task automatic issue_operation(input logic [OP_W-1:0] code,
                                 input logic [DATA_W-1:0] value);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    operation_i  <= code;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_views.push_back(next_deque_view(code, value));
    // optional idle burst after the transaction
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random pushes and pops at random ends plus occasional peeks, biased toward filling or draining
  task automatic random_phase(input int unsigned push_share, input int unsigned items);
    int unsigned       roll;
    logic [OP_W-1:0]   code;
    logic [DATA_W-1:0] value;
    for (int unsigned i = 0; i < items; i++) begin
      roll  = $urandom_range(0, 99);
      value = DATA_W'($urandom_range(0, 255));
      if (roll < 6) begin
        code = OP_PEEK;
      end else if (roll < push_share) begin
        code = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        code = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      issue_operation(code, value);
    end
  endtask

  // empty-queue behavior, both byte extremes at both ends, spare codes
  task automatic test_directed_ends();
    issue_operation(OP_PEEK, 8'h5a);
    issue_operation(OP_POP_BACK, 8'h00);   // pop on empty queue
    issue_operation(OP_POP_FRONT, 8'hff);  // pop on empty queue
    issue_operation(OP_PUSH_BACK, 8'h00);
    issue_operation(OP_PUSH_FRONT, 8'hff);
    for (int unsigned c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
      issue_operation(OP_W'(c), 8'ha5);
    end
    issue_operation(OP_POP_BACK, 8'hff);
    issue_operation(OP_POP_FRONT, 8'h00);
  endtask

  // fill from both ends across the ring wrap, then push into a full queue
  task automatic test_fill_and_overflow();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      issue_operation(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, DATA_W'(i * 17));
    end
    issue_operation(OP_PUSH_BACK, 8'h3c);
    issue_operation(OP_PUSH_FRONT, 8'hc3);
  endtask

  // alternating fill and drain phases; some phases run without idling
  task automatic test_random_walk();
    for (int unsigned p = 0; p < WALK_PHASES; p++) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      random_phase(p[0] ? DRAIN_SHARE : FILL_SHARE, WALK_PHASE_LEN);
    end
    idle_enable = 1'b1;
  endtask

  // every opcode value with equal weight, spare codes included
  task automatic test_random_noise();
    for (int unsigned i = 0; i < NOISE_ITEMS; i++) begin
      issue_operation(OP_W'($urandom_range(0, 7)), DATA_W'($urandom_range(0, 255)));
    end
  endtask

  // closing stream at full rate, no idling on either side
  task automatic test_streaming();
    idle_enable = 1'b0;
    random_phase(FILL_SHARE, STREAM_ITEMS);
    random_phase(DRAIN_SHARE, STREAM_ITEMS);
  endtask

  // random receiver stall bursts while idling is enabled
  always @(posedge clk_i) begin
    if (!idle_enable) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each accepted output transaction with the oldest prediction
  always @(posedge clk_i) begin
    deque_view_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_views.size() == 0) begin
        error_count++;
        $error("output transaction with no prediction pending");
      end else begin
        want = pending_views.pop_front();
        check_field("front_value", want.front_value, front_value_o);
        check_field("back_value", want.back_value, back_value_o);
        check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(entry_count_o));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty_o));
        check_field("is_full", DATA_W'(want.is_full), DATA_W'(is_full_o));
        check_field("push_dropped", DATA_W'(want.push_dropped), DATA_W'(push_dropped_o));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ends();
    test_fill_and_overflow();
    test_random_walk();
    test_random_noise();
    test_streaming();
    in_valid_i <= 1'b0;

    // let outstanding predictions arrive, then watch for stray outputs
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("byte_double_ended_queue_tb passed");
    end else begin
      $display("byte_double_ended_queue_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("byte_double_ended_queue_tb failed");
    $finish;
  end

endmodule
